// File: sv/bctc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Block cache tag controller package
// Shared widths, operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package bctc_pkg;

    // Fixed field widths of the request, response and configuration channels.
    localparam int MODE_W    = 2;
    localparam int LBA_W     = 48;
    localparam int SPAN_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int WAY_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;

    // Defaults for the top level parameters.
    localparam int DEF_ENTRIES  = 64;
    localparam int DEF_LBA_BITS = 48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ENABLE  = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_INVAL = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RANGE,
        S_SCAN,
        S_ALLOC,
        S_DONE
    } t_state;

endpackage : bctc_pkg
`default_nettype wire

// File: sv/bctc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Block cache tag controller channels
// Valid/ready channels for requests, responses and configuration writes.
// ----------------------------------------------------------------------------
interface bctc_req_if;
    import bctc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LBA_W-1:0]  lba;
    logic [SPAN_W-1:0] span;

    modport source (output valid, output mode, output lba, output span, input ready);
    modport sink   (input valid, input mode, input lba, input span, output ready);
endinterface : bctc_req_if

interface bctc_rsp_if;
    import bctc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [WAY_W-1:0]    way;

    modport source (output valid, output status, output hit, output way, input ready);
    modport sink   (input valid, input status, input hit, input way, output ready);
endinterface : bctc_rsp_if

interface bctc_cfg_if;
    import bctc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : bctc_cfg_if
`default_nettype wire

// File: sv/block_cache_tag_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Block cache tag controller
// Tag store of a fully associative block cache with round-robin replacement:
// read and write lookup, fill after a device read and invalidate all.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                         Transfer when
//  i_req     in   mode, lba, span                 i_req.valid & i_req.ready
//  o_rsp     out  status, hit, way                o_rsp.valid & o_rsp.ready
//  i_cfg     in   index, data (device_blocks,     i_cfg.valid & i_cfg.ready
//                 cache_enable)
//
// Sequencing: one request is handled at a time. The tags sit in a single-port
// memory and one comparator walks it, one entry per cycle, lowest index
// first, stopping at the first valid match. Invalidate and the early
// exits (empty request, out of range, cache disabled) skip the scan.
// Reset: i_rst_n is synchronous and active low; it clears all valid bits,
// the replacement pointer and the configuration (device_blocks 0,
// cache_enable 1). The tag memory itself is not cleared.
// Stalls: the response sits in an output register, so the next request is
// taken while a response still waits; a finished lookup waits only if the
// output register is still full. The configuration port is always ready.
//
module block_cache_tag_controller #(
    parameter int ENTRIES  = bctc_pkg::DEF_ENTRIES,
    parameter int LBA_BITS = bctc_pkg::DEF_LBA_BITS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    bctc_req_if.sink     i_req,
    bctc_rsp_if.source   o_rsp,
    bctc_cfg_if.sink     i_cfg
);
    import bctc_pkg::*;

    // Index width of the entry array and width of a stored tag. Only the low
    // LBA_BITS bits of a block address take part, and never more than the
    // channel carries.
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TAG_BITS = (LBA_BITS < LBA_W) ? LBA_BITS : LBA_W;
    localparam logic [LBA_W-1:0] LBA_MASK = LBA_W'((65'd1 << TAG_BITS) - 65'd1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Sequencer state.
    t_state r_state, n_state;

    // Configuration registers.
    logic [LBA_W-1:0] r_dev;
    logic             r_en;

    // Latched request.
    t_mode             r_mode,  n_mode;
    logic [LBA_W-1:0]  r_lba,   n_lba;
    logic [SPAN_W-1:0] r_span,  n_span;

    // Range check results.
    logic              r_borrow, n_borrow;
    logic [LBA_W-1:0]  r_room,   n_room;

    // Entry state.
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [IDX_W-1:0]   r_ptr,   n_ptr;
    logic [TAG_BITS-1:0] r_tag_mem [ENTRIES];

    // Scan pipeline: read address, issue done flag, and the entry whose tag
    // is in the read data register.
    logic [IDX_W-1:0]    r_idx,       n_idx;
    logic                r_issue_end, n_issue_end;
    logic                r_pend,      n_pend;
    logic [IDX_W-1:0]    r_pend_idx,  n_pend_idx;
    logic [TAG_BITS-1:0] r_rd_tag;

    // Result under construction and output register.
    t_status          r_res_status, n_res_status;
    logic             r_res_hit,    n_res_hit;
    logic [WAY_W-1:0] r_res_way,    n_res_way;
    logic             r_out_valid,  n_out_valid;
    t_status          r_out_status, n_out_status;
    logic             r_out_hit,    n_out_hit;
    logic [WAY_W-1:0] r_out_way,    n_out_way;

    logic w_req_xfer;
    logic w_out_free;
    logic w_match;
    logic w_last;
    logic w_oor;
    logic [IDX_W+WAY_W-1:0] w_pend_way_x;
    logic [IDX_W+WAY_W-1:0] w_ptr_way_x;
    logic [LBA_W:0]         w_diff;

    assign i_req.ready  = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.hit    = r_out_hit;
    assign o_rsp.way    = r_out_way;

    assign w_req_xfer = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // The shared comparator: tag of the entry read last cycle against the
    // requested address, gated by that entry's valid bit.
    assign w_match = r_pend && r_valid[r_pend_idx] && (r_rd_tag == r_lba[TAG_BITS-1:0]);
    assign w_last  = r_pend && (r_pend_idx == LAST_IDX);

    // The way field is the low bits of the entry index.
    assign w_pend_way_x = {{WAY_W{1'b0}}, r_pend_idx};
    assign w_ptr_way_x  = {{WAY_W{1'b0}}, r_ptr};

    // Room left on the device from the address on; a borrow means the
    // address lies beyond the last block.
    assign w_diff = {1'b0, r_dev} - {1'b0, r_lba};
    // An address equal to device_blocks leaves no room, so any non-empty
    // span fails as it should.
    assign w_oor  = r_borrow || ({{(LBA_W-SPAN_W){1'b0}}, r_span} > r_room);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_xfer) begin
                    unique case (t_mode'(i_req.mode))
                        MODE_INVAL: n_state = S_DONE;
                        MODE_FILL:  n_state = r_en ? S_SCAN : S_DONE;
                        MODE_READ, MODE_WRITE: begin
                            n_state = (i_req.span == '0) ? S_DONE : S_CHECK;
                        end
                    endcase
                end
            end
            S_CHECK: n_state = S_RANGE;
            S_RANGE: n_state = (w_oor || !r_en) ? S_DONE : S_SCAN;
            S_SCAN: begin
                if (w_match) begin
                    n_state = S_DONE;
                end else if (w_last) begin
                    n_state = (r_mode == MODE_FILL) ? S_ALLOC : S_DONE;
                end
            end
            S_ALLOC: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_mode       = r_mode;
        n_lba        = r_lba;
        n_span       = r_span;
        n_borrow     = r_borrow;
        n_room       = r_room;
        n_valid      = r_valid;
        n_ptr        = r_ptr;
        n_idx        = '0;
        n_issue_end  = 1'b0;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_res_status = r_res_status;
        n_res_hit    = r_res_hit;
        n_res_way    = r_res_way;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_hit    = r_out_hit;
        n_out_way    = r_out_way;

        unique case (r_state)
            S_IDLE: begin
                if (w_req_xfer) begin
                    n_mode       = t_mode'(i_req.mode);
                    n_lba        = i_req.lba & LBA_MASK;
                    n_span       = i_req.span;
                    n_res_status = ST_DONE;
                    n_res_hit    = 1'b0;
                    n_res_way    = '0;
                    unique case (t_mode'(i_req.mode))
                        MODE_INVAL: begin
                            n_valid = '0;
                            n_ptr   = '0;
                        end
                        MODE_FILL: begin
                        end
                        MODE_READ, MODE_WRITE: begin
                            if (i_req.span == '0) begin
                                n_res_status = ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_CHECK: begin
                n_borrow = w_diff[LBA_W];
                n_room   = w_diff[LBA_W-1:0];
            end
            S_RANGE: begin
                if (w_oor) begin
                    n_res_status = ST_RANGE;
                end
            end
            S_SCAN: begin
                // Issue one tag read per cycle until the last entry.
                n_idx       = r_idx;
                n_issue_end = r_issue_end;
                if (!r_issue_end) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_issue_end = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (w_match) begin
                    n_res_hit = 1'b1;
                    n_res_way = w_pend_way_x[WAY_W-1:0];
                end
            end
            S_ALLOC: begin
                n_valid[r_ptr] = 1'b1;
                n_ptr          = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
                n_res_way      = w_ptr_way_x[WAY_W-1:0];
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_hit    = r_res_hit;
                    n_out_way    = r_res_way;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dev       <= '0;
            r_en        <= 1'b1;
            r_valid     <= '0;
            r_ptr       <= '0;
            r_idx       <= '0;
            r_issue_end <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_ptr       <= n_ptr;
            r_idx       <= n_idx;
            r_issue_end <= n_issue_end;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_DEVICE_BLOCKS: r_dev <= i_cfg.data[LBA_W-1:0];
                    CFG_CACHE_ENABLE:  r_en  <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_lba        <= n_lba;
        r_span       <= n_span;
        r_borrow     <= n_borrow;
        r_room       <= n_room;
        r_pend_idx   <= n_pend_idx;
        r_res_status <= n_res_status;
        r_res_hit    <= n_res_hit;
        r_res_way    <= n_res_way;
        r_out_status <= n_out_status;
        r_out_hit    <= n_out_hit;
        r_out_way    <= n_out_way;
    end

    // Tag memory: one write on allocation, one registered read per scan step.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ALLOC) begin
            r_tag_mem[r_ptr] <= r_lba[TAG_BITS-1:0];
        end
        if ((r_state == S_SCAN) && !r_issue_end) begin
            r_rd_tag <= r_tag_mem[r_idx];
        end
    end

endmodule : block_cache_tag_controller
`default_nettype wire
